### design/gregorian_date_arithmetic_top_assert.svh
// Assertion macros shared by the checker of the Gregorian date unit.
`ifndef GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define GDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off while rst_ni is low.
`define GDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/gda_pkg.sv
// Types, constants and calendar tables of the Gregorian date unit.
package gda_pkg;

  // Range limits of the calendar and of the shift count.
  localparam int unsigned YEAR_MAX  = 9999;
  localparam int unsigned SHIFT_MAX = 65535;

  // Field widths.
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned SHIFT_W = 16;
  localparam int unsigned DOY_W   = 9;
  localparam int unsigned GAP_W   = 22;

  // Stream payload sizes.
  localparam int unsigned IN_FIELDS_W  = 65;
  localparam int unsigned IN_DATA_W    = 72;
  localparam int unsigned OUT_FIELDS_W = 59;
  localparam int unsigned OUT_DATA_W   = 64;

  // Day counts of the Gregorian cycles.
  localparam int unsigned DAYS_400Y = 146097;
  localparam int unsigned DAYS_100Y = 36524;
  localparam int unsigned DAYS_4Y   = 1461;
  localparam int unsigned DAYS_1Y   = 365;

  // x / 25 == (x * RECIP_25) >> RECIP_SHIFT, exact for x below 4096.
  localparam int unsigned RECIP_25    = 2622;
  localparam int unsigned RECIP_SHIFT = 16;

  // Serial day number of 31 December of the last year.
  localparam int unsigned YEAR_PREV   = YEAR_MAX - 1;
  localparam bit          LEAP_AT_MAX = ((YEAR_MAX % 4) == 0) &&
                                        (((YEAR_MAX % 100) != 0) || ((YEAR_MAX % 400) == 0));
  localparam int unsigned TOP_SERIAL  = YEAR_PREV * 365 + YEAR_PREV / 4 - YEAR_PREV / 100 +
                                        YEAR_PREV / 400 + (LEAP_AT_MAX ? 366 : 365);

  // Serial width covers the last day plus the largest shift, and the saturated gap.
  localparam int unsigned SERIAL_W_RAW = $clog2(TOP_SERIAL + SHIFT_MAX + 2);
  localparam int unsigned SERIAL_W     = (SERIAL_W_RAW > GAP_W + 1) ? SERIAL_W_RAW : GAP_W + 1;
  localparam int unsigned GAP_SAT      = (1 << GAP_W) - 1;
  localparam int unsigned YACC_W       = $clog2(YEAR_MAX + 1);
  localparam int unsigned SHIFT_CAP    = (SHIFT_MAX < 65535) ? SHIFT_MAX : 65535;

  // Request commands.
  typedef enum logic [CMD_W-1:0] {
    CMD_NEXT = 3'd0,
    CMD_PREV = 3'd1,
    CMD_ADD  = 3'd2,
    CMD_SUB  = 3'd3,
    CMD_GAP  = 3'd4
  } gda_cmd_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_EVAL_A,
    DP_EVAL_B,
    DP_CALC,
    DP_STEP_400,
    DP_STEP_100,
    DP_STEP_4,
    DP_STEP_1,
    DP_STEP_MON,
    DP_FINISH
  } dp_op_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAIN_A,
    ST_MAIN_B,
    ST_OTHER_A,
    ST_OTHER_B,
    ST_CALC,
    ST_Y400,
    ST_Y100,
    ST_Y4,
    ST_Y1,
    ST_MONTH,
    ST_DONE
  } gda_state_e;

  // Request fields, first field in the lowest bits.
  typedef struct packed {
    logic [YEAR_W-1:0]  other_year;
    logic [MONTH_W-1:0] other_month;
    logic [DAY_W-1:0]   other_day;
    logic [SHIFT_W-1:0] shift_count;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [CMD_W-1:0]   command;
  } gda_req_t;

  // Result fields, first field in the lowest bits.
  typedef struct packed {
    logic               date_error;
    logic               is_leap;
    logic               is_equal;
    logic               is_earlier;
    logic               is_later;
    logic [GAP_W-1:0]   day_gap;
    logic [DOY_W-1:0]   day_of_year;
    logic [YEAR_W-1:0]  result_year;
    logic [MONTH_W-1:0] result_month;
    logic [DAY_W-1:0]   result_day;
  } gda_res_t;

  // Controller to datapath.
  typedef struct packed {
    dp_op_e op;
    logic   sel_other;
  } dp_ctrl_t;

  // Datapath to controller.
  typedef struct packed {
    logic date_ok;
    logic cmd_ok;
    logic is_gap;
    logic range_err;
    logic step_more;
    logic out_free;
  } dp_stat_t;

  // Length of a month; zero for a month code outside 1 to 12.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m)
      4'd2:                                    return leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                 return 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
      default:                                 return 5'd0;
    endcase
  endfunction

  // Days before the first of a month in a common year.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    case (m)
      4'd1:    return 9'd0;
      4'd2:    return 9'd31;
      4'd3:    return 9'd59;
      4'd4:    return 9'd90;
      4'd5:    return 9'd120;
      4'd6:    return 9'd151;
      4'd7:    return 9'd181;
      4'd8:    return 9'd212;
      4'd9:    return 9'd243;
      4'd10:   return 9'd273;
      4'd11:   return 9'd304;
      4'd12:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

endpackage

### design/gda_ctrl.sv
// Controller state machine of the Gregorian date unit.
module gda_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  gda_pkg::dp_stat_t  stat_i,
  output gda_pkg::dp_ctrl_t  ctrl_o
);

  gda_pkg::gda_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gda_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gda_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gda_pkg::ST_MAIN_A;
      end
      gda_pkg::ST_MAIN_A: state_d = gda_pkg::ST_MAIN_B;
      gda_pkg::ST_MAIN_B: begin
        if (!stat_i.cmd_ok || !stat_i.date_ok) begin
          state_d = gda_pkg::ST_DONE;
        end else if (stat_i.is_gap) begin
          state_d = gda_pkg::ST_OTHER_A;
        end else begin
          state_d = gda_pkg::ST_CALC;
        end
      end
      gda_pkg::ST_OTHER_A: state_d = gda_pkg::ST_OTHER_B;
      gda_pkg::ST_OTHER_B: begin
        state_d = stat_i.date_ok ? gda_pkg::ST_CALC : gda_pkg::ST_DONE;
      end
      gda_pkg::ST_CALC: begin
        state_d = stat_i.range_err ? gda_pkg::ST_DONE : gda_pkg::ST_Y400;
      end
      gda_pkg::ST_Y400: begin
        if (!stat_i.step_more) state_d = gda_pkg::ST_Y100;
      end
      gda_pkg::ST_Y100: begin
        if (!stat_i.step_more) state_d = gda_pkg::ST_Y4;
      end
      gda_pkg::ST_Y4: begin
        if (!stat_i.step_more) state_d = gda_pkg::ST_Y1;
      end
      gda_pkg::ST_Y1: begin
        if (!stat_i.step_more) state_d = gda_pkg::ST_MONTH;
      end
      gda_pkg::ST_MONTH: begin
        if (!stat_i.step_more) state_d = gda_pkg::ST_DONE;
      end
      gda_pkg::ST_DONE: begin
        if (stat_i.out_free) state_d = gda_pkg::ST_IDLE;
      end
      default: state_d = gda_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands and input handshake.
  always_comb begin
    in_ready_o       = 1'b0;
    ctrl_o.op        = gda_pkg::DP_NOP;
    ctrl_o.sel_other = 1'b0;
    case (state_q)
      gda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) ctrl_o.op = gda_pkg::DP_LOAD;
      end
      gda_pkg::ST_MAIN_A:  ctrl_o.op = gda_pkg::DP_EVAL_A;
      gda_pkg::ST_MAIN_B:  ctrl_o.op = gda_pkg::DP_EVAL_B;
      gda_pkg::ST_OTHER_A: begin
        ctrl_o.op        = gda_pkg::DP_EVAL_A;
        ctrl_o.sel_other = 1'b1;
      end
      gda_pkg::ST_OTHER_B: begin
        ctrl_o.op        = gda_pkg::DP_EVAL_B;
        ctrl_o.sel_other = 1'b1;
      end
      gda_pkg::ST_CALC:  ctrl_o.op = gda_pkg::DP_CALC;
      gda_pkg::ST_Y400:  ctrl_o.op = gda_pkg::DP_STEP_400;
      gda_pkg::ST_Y100:  ctrl_o.op = gda_pkg::DP_STEP_100;
      gda_pkg::ST_Y4:    ctrl_o.op = gda_pkg::DP_STEP_4;
      gda_pkg::ST_Y1:    ctrl_o.op = gda_pkg::DP_STEP_1;
      gda_pkg::ST_MONTH: ctrl_o.op = gda_pkg::DP_STEP_MON;
      gda_pkg::ST_DONE: begin
        if (stat_i.out_free) ctrl_o.op = gda_pkg::DP_FINISH;
      end
      default: ctrl_o.op = gda_pkg::DP_NOP;
    endcase
  end

endmodule

### design/gda_datapath.sv
// Datapath of the Gregorian date unit: date check, serial numbers and date rebuild.
module gda_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gda_pkg::dp_ctrl_t                 ctrl_i,
  output gda_pkg::dp_stat_t                 stat_o,
  input  logic [gda_pkg::IN_DATA_W-1:0]     req_data_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [gda_pkg::OUT_DATA_W-1:0]    out_data_o
);

  localparam int unsigned SW = gda_pkg::SERIAL_W;

  gda_pkg::gda_req_t req_in, req_q;

  // Per-date evaluation registers.
  logic [gda_pkg::YEAR_W-1:0] p_q;
  logic [22:0]                p365_q;
  logic [7:0]                 q100_q;
  logic [7:0]                 q400_q;
  logic                       main_ok_q, other_ok_q, leap_q;
  logic [gda_pkg::DOY_W-1:0]  doy_q;
  logic [SW-1:0]              s_q, o_q;

  // Gap results.
  logic [gda_pkg::GAP_W-1:0]  gap_q;
  logic                       later_q, earlier_q, equal_q;

  // Date rebuild registers.
  logic [SW-1:0]                   n_q;
  logic [1:0]                      cent_q;
  logic [4:0]                      quad_q;
  logic [1:0]                      yr_q;
  logic [gda_pkg::YACC_W-1:0]      yacc_q;
  logic [gda_pkg::MONTH_W-1:0]     mon_q;

  gda_pkg::gda_res_t out_q, res;
  logic              out_valid_q;

  // Request unpacking with the shift count clamped.
  always_comb begin
    req_in = gda_pkg::gda_req_t'(req_data_i[gda_pkg::IN_FIELDS_W-1:0]);
    if (32'(req_in.shift_count) > gda_pkg::SHIFT_CAP) begin
      req_in.shift_count = gda_pkg::SHIFT_W'(gda_pkg::SHIFT_CAP);
    end
  end

  // Date under evaluation.
  logic [gda_pkg::DAY_W-1:0]   sel_day;
  logic [gda_pkg::MONTH_W-1:0] sel_month;
  logic [gda_pkg::YEAR_W-1:0]  sel_year;
  assign sel_day   = ctrl_i.sel_other ? req_q.other_day   : req_q.day;
  assign sel_month = ctrl_i.sel_other ? req_q.other_month : req_q.month;
  assign sel_year  = ctrl_i.sel_other ? req_q.other_year  : req_q.year;

  // First evaluation step: years before, times 365, and century quotients.
  logic [gda_pkg::YEAR_W-1:0] p_new;
  logic [23:0]                prod100, prod400;
  assign p_new   = sel_year - gda_pkg::YEAR_W'(1);
  assign prod100 = 24'(p_new[13:2]) * 24'(gda_pkg::RECIP_25);
  assign prod400 = 24'(p_new[13:4]) * 24'(gda_pkg::RECIP_25);

  // Second evaluation step: leap year, validity, day of year and serial number.
  logic [gda_pkg::YEAR_W-1:0]  r100, r400;
  logic                        eval_leap, eval_ok;
  logic [gda_pkg::DAY_W-1:0]   eval_len;
  logic [gda_pkg::DOY_W-1:0]   eval_doy;
  logic [SW-1:0]               eval_serial;
  always_comb begin
    r100      = p_q - gda_pkg::YEAR_W'(16'(q100_q) * 16'd100);
    r400      = p_q - gda_pkg::YEAR_W'(16'(q400_q) * 16'd400);
    eval_leap = (p_q[1:0] == 2'b11) && ((r100 != 14'd99) || (r400 == 14'd399));
    eval_len  = gda_pkg::month_len(sel_month, eval_leap);
    eval_ok   = (sel_year != '0) && (32'(sel_year) <= gda_pkg::YEAR_MAX) &&
                (sel_month >= 4'd1) && (sel_month <= 4'd12) &&
                (sel_day != '0) && (sel_day <= eval_len);
    eval_doy  = gda_pkg::cum_days(sel_month) + gda_pkg::DOY_W'(sel_day) +
                gda_pkg::DOY_W'(eval_leap && (sel_month > 4'd2));
    eval_serial = SW'(p365_q) + SW'(p_q[13:2]) - SW'(q100_q) + SW'(q400_q) + SW'(eval_doy);
  end

  // Target serial number and range check.
  logic          cmd_ok, is_gap, go_back, range_err;
  logic [SW-1:0] amt, t_fwd, t_back, t_new;
  always_comb begin
    cmd_ok  = (req_q.command <= gda_pkg::CMD_GAP);
    is_gap  = (req_q.command == gda_pkg::CMD_GAP);
    go_back = (req_q.command == gda_pkg::CMD_PREV) || (req_q.command == gda_pkg::CMD_SUB);
    case (req_q.command)
      gda_pkg::CMD_NEXT, gda_pkg::CMD_PREV: amt = SW'(1);
      gda_pkg::CMD_ADD, gda_pkg::CMD_SUB:   amt = SW'(req_q.shift_count);
      default:                              amt = '0;
    endcase
    t_fwd     = s_q + amt;
    t_back    = s_q - amt;
    t_new     = go_back ? t_back : t_fwd;
    range_err = go_back ? (amt >= s_q) : (t_fwd > SW'(gda_pkg::TOP_SERIAL));
  end

  // Distance between the two dates.
  logic [SW-1:0] span;
  assign span = (s_q > o_q) ? (s_q - o_q) : (o_q - s_q);

  // Leap flag of the rebuilt year, from its place in the cycles.
  logic leap_res;
  assign leap_res = (yr_q == 2'd3) && ((quad_q != 5'd24) || (cent_q == 2'd3));

  // Subtraction step of the rebuild loops.
  logic [SW-1:0] step_k;
  logic          step_cap, step_more;
  always_comb begin
    step_k   = '0;
    step_cap = 1'b0;
    case (ctrl_i.op)
      gda_pkg::DP_STEP_400: step_k = SW'(gda_pkg::DAYS_400Y);
      gda_pkg::DP_STEP_100: begin
        step_k   = SW'(gda_pkg::DAYS_100Y);
        step_cap = (cent_q == 2'd3);
      end
      gda_pkg::DP_STEP_4: step_k = SW'(gda_pkg::DAYS_4Y);
      gda_pkg::DP_STEP_1: begin
        step_k   = SW'(gda_pkg::DAYS_1Y);
        step_cap = (yr_q == 2'd3);
      end
      gda_pkg::DP_STEP_MON: begin
        step_k   = SW'(gda_pkg::month_len(mon_q, leap_res));
        step_cap = (mon_q == 4'd12);
      end
      default: step_cap = 1'b1;
    endcase
    step_more = !step_cap && (n_q >= step_k);
  end

  // Result assembly.
  always_comb begin
    res = '0;
    if (!cmd_ok || !main_ok_q) begin
      res.date_error = 1'b1;
    end else begin
      res.day_of_year = doy_q;
      res.is_leap     = leap_q;
      if (is_gap && !other_ok_q) begin
        res.date_error = 1'b1;
      end else begin
        if (is_gap) begin
          res.day_gap    = gap_q;
          res.is_later   = later_q;
          res.is_earlier = earlier_q;
          res.is_equal   = equal_q;
        end
        if (range_err) begin
          res.date_error = 1'b1;
        end else begin
          res.result_day   = n_q[gda_pkg::DAY_W-1:0] + gda_pkg::DAY_W'(1);
          res.result_month = mon_q;
          res.result_year  = gda_pkg::YEAR_W'(yacc_q);
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      gda_pkg::DP_LOAD: req_q <= req_in;
      gda_pkg::DP_EVAL_A: begin
        p_q    <= p_new;
        p365_q <= 23'(p_new) * 23'(gda_pkg::DAYS_1Y);
        q100_q <= prod100[23:gda_pkg::RECIP_SHIFT];
        q400_q <= prod400[23:gda_pkg::RECIP_SHIFT];
      end
      gda_pkg::DP_EVAL_B: begin
        if (ctrl_i.sel_other) begin
          other_ok_q <= eval_ok;
          o_q        <= eval_serial;
        end else begin
          main_ok_q <= eval_ok;
          leap_q    <= eval_leap;
          doy_q     <= eval_doy;
          s_q       <= eval_serial;
        end
      end
      gda_pkg::DP_CALC: begin
        n_q       <= t_new - SW'(1);
        cent_q    <= '0;
        quad_q    <= '0;
        yr_q      <= '0;
        yacc_q    <= gda_pkg::YACC_W'(1);
        mon_q     <= gda_pkg::MONTH_W'(1);
        gap_q     <= (span > SW'(gda_pkg::GAP_SAT)) ? gda_pkg::GAP_W'(gda_pkg::GAP_SAT)
                                                   : span[gda_pkg::GAP_W-1:0];
        later_q   <= (s_q > o_q);
        earlier_q <= (s_q < o_q);
        equal_q   <= (s_q == o_q);
      end
      gda_pkg::DP_STEP_400: begin
        if (step_more) begin
          n_q    <= n_q - step_k;
          yacc_q <= yacc_q + gda_pkg::YACC_W'(400);
        end
      end
      gda_pkg::DP_STEP_100: begin
        if (step_more) begin
          n_q    <= n_q - step_k;
          cent_q <= cent_q + 2'd1;
          yacc_q <= yacc_q + gda_pkg::YACC_W'(100);
        end
      end
      gda_pkg::DP_STEP_4: begin
        if (step_more) begin
          n_q    <= n_q - step_k;
          quad_q <= quad_q + 5'd1;
          yacc_q <= yacc_q + gda_pkg::YACC_W'(4);
        end
      end
      gda_pkg::DP_STEP_1: begin
        if (step_more) begin
          n_q    <= n_q - step_k;
          yr_q   <= yr_q + 2'd1;
          yacc_q <= yacc_q + gda_pkg::YACC_W'(1);
        end
      end
      gda_pkg::DP_STEP_MON: begin
        if (step_more) begin
          n_q   <= n_q - step_k;
          mon_q <= mon_q + gda_pkg::MONTH_W'(1);
        end
      end
      gda_pkg::DP_FINISH: out_q <= res;
      default: ;
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == gda_pkg::DP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Status back to the controller.
  assign stat_o.date_ok   = eval_ok;
  assign stat_o.cmd_ok    = cmd_ok;
  assign stat_o.is_gap    = is_gap;
  assign stat_o.range_err = range_err;
  assign stat_o.step_more = step_more;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(gda_pkg::OUT_DATA_W - gda_pkg::OUT_FIELDS_W){1'b0}}, out_q};

endmodule

### design/gregorian_date_arithmetic_top.sv
// Top level of the Gregorian date unit.
//
//   Channel  Direction  Handshake                    Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  one date request per transfer
//   m_axis   out        m_axis_tvalid/m_axis_tready  one date result per request
//
// One request is worked on at a time. After acceptance the result is offered after the check
// that fails for a bad command or main date, a shift out of range or a gap with a bad second
// date, and otherwise after the rebuild loops that peel 400-year, 100-year, 4-year, 1-year
// and month spans off the serial day number with one subtraction per cycle.
// The next request is taken in the cycle after the result is loaded. Reset clears the controller
// and the output valid flag; a stalled result holds the next one back, not the next request.
module gregorian_date_arithmetic_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // command, day, month, year, shift_count, other_day, other_month, other_year, zero pad
  input  logic [gda_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_day, result_month, result_year, day_of_year, day_gap, is_later,
  // is_earlier, is_equal, is_leap, date_error, zero pad
  output logic [gda_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  gda_pkg::dp_ctrl_t ctrl;
  gda_pkg::dp_stat_t stat;

  // Sequencer.
  gda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  // Arithmetic and result register.
  gda_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .req_data_i  (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

### design/gda_checker.sv
// Port-level checks of the Gregorian date unit, bound to its top level.
`include "gregorian_date_arithmetic_top_assert.svh"

module gda_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [gda_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  gda_pkg::gda_res_t res;
  assign res = gda_pkg::gda_res_t'(m_axis_tdata[gda_pkg::OUT_FIELDS_W-1:0]);

  // A stalled result stays offered.
  `GDA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")

  // Only one request is taken at a time.
  `GDA_ASSERT_NXT(a_in_single, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request overlap")

  // An error result carries no date.
  `GDA_ASSERT_IMP(a_err_no_date, m_axis_tvalid && res.date_error, res.result_day == '0 && res.result_month == '0 && res.result_year == '0, "error result with a date")

  // At most one of the comparison flags is set.
  `GDA_ASSERT_IMP(a_cmp_onehot, m_axis_tvalid, $onehot0({res.is_later, res.is_earlier, res.is_equal}), "comparison flags overlap")

  // Equal dates have no gap.
  `GDA_ASSERT_IMP(a_equal_gap, m_axis_tvalid && res.is_equal, res.day_gap == '0, "equal dates with a gap")

endmodule

bind gregorian_date_arithmetic_top gda_checker u_gda_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
